// ===== hw/rtl/adaptive_threshold_integral_macros.svh =====
// Assertion macros shared by the checker of the adaptive threshold block.
`ifndef ADAPTIVE_THRESHOLD_INTEGRAL_MACROS_SVH
`define ADAPTIVE_THRESHOLD_INTEGRAL_MACROS_SVH

// Implication checked in the next cycle, masked while in reset.
`define ATI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, also during reset.
`define ATI_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/atint_pkg.sv =====
// Types and constants shared by the adaptive threshold modules.
`default_nettype none
package atint_pkg;

    localparam int POS_W      = 12;
    localparam int PIX_W      = 8;
    localparam int HALF_W     = 3;
    localparam int THR_W      = 16;
    localparam int CFG_W      = 16;
    localparam int TDATA_W    = 24;
    localparam int OUT_POS_W  = 11;
    localparam int JOBQ_DEPTH = 2;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;
    localparam logic [1:0] REG_THRESHOLD    = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  w_m1;
        logic [POS_W-1:0]  h_m1;
        logic [HALF_W-1:0] half;
        logic [THR_W-1:0]  thr;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] rlo;
        logic [POS_W-1:0] rhi;
        logic [POS_W-1:0] clo;
        logic [POS_W-1:0] chi;
        logic [POS_W-1:0] row;
        logic [3:0]       islot;
        logic [2:0]       pslot;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_CALC
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_READ,
        B_DRAIN,
        B_MUL,
        B_OUT
    } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/atint_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module atint_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/atint_front.sv =====
// Front end: accepts pixels, builds the integral image and issues window jobs.
`default_nettype none
module atint_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire atint_pkg::cfg_t       cfg,
    input  wire logic                  restart,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,
    output logic                       int_we,
    output logic [$clog2((MAX_WINDOW+1)*(2**$clog2(MAX_WIDTH)))-1:0] int_waddr,
    output logic [$clog2(longint'(MAX_WIDTH)*MAX_HEIGHT*255+1)-1:0] int_wdata,
    output logic [$clog2((MAX_WINDOW+1)*(2**$clog2(MAX_WIDTH)))-1:0] int_raddr,
    input  wire logic [$clog2(longint'(MAX_WIDTH)*MAX_HEIGHT*255+1)-1:0] int_rdata,
    output logic                       pix_we,
    output logic [$clog2((MAX_WINDOW/2+1)*(2**$clog2(MAX_WIDTH)))-1:0] pix_waddr,
    output logic [7:0]                 pix_wdata,
    input  wire logic                  q_empty,
    output logic                       q_push,
    output atint_pkg::job_t            q_job
);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int INT_ROWS = MAX_WINDOW + 1;
    localparam int PIX_ROWS = MAX_WINDOW / 2 + 1;
    localparam int ISW      = $clog2(INT_ROWS);
    localparam int PSW      = (PIX_ROWS > 1) ? $clog2(PIX_ROWS) : 1;
    localparam int IW       = $clog2(longint'(MAX_WIDTH) * MAX_HEIGHT * 255 + 1);
    localparam int IAW      = $clog2(INT_ROWS * (2**CW));
    localparam int PAW      = $clog2(PIX_ROWS * (2**CW));

    atint_pkg::front_state_t state_reg, state_next;

    logic [atint_pkg::POS_W-1:0] row_reg, col_reg;
    logic [ISW-1:0]              islot_reg;
    logic [PSW-1:0]              pslot_reg;
    logic [IW-1:0]               rowsum_reg;
    logic [7:0]                  pix_reg;

    logic                        wrap;
    logic [atint_pkg::POS_W-1:0] row_e, col_e, half12, rlo, clo;
    logic [ISW-1:0]              islot_e, above_slot;
    logic [PSW-1:0]              pslot_e;
    logic [IW-1:0]               above, rowsum_new;
    logic                        accept, rows_ok, cols_ok;

    assign accept = s_tvalid && s_tready;

    // Restart the frame when the stored position falls outside the geometry.
    always_comb begin
        wrap       = (row_reg > cfg.h_m1) || (col_reg > cfg.w_m1);
        row_e      = wrap ? '0 : row_reg;
        col_e      = wrap ? '0 : col_reg;
        islot_e    = wrap ? '0 : islot_reg;
        pslot_e    = wrap ? '0 : pslot_reg;
        above_slot = (islot_e == '0) ? ISW'(INT_ROWS - 1) : islot_e - 1'b1;
        int_raddr  = IAW'({above_slot, col_e[CW-1:0]});
    end

    always_comb begin
        above      = (row_reg != '0) ? int_rdata : '0;
        rowsum_new = ((col_reg == '0) ? '0 : rowsum_reg) + IW'(pix_reg);
        int_wdata  = above + rowsum_new;
        int_waddr  = IAW'({islot_reg, col_reg[CW-1:0]});
        pix_waddr  = PAW'({pslot_reg, col_reg[CW-1:0]});
        pix_wdata  = pix_reg;
        half12     = atint_pkg::POS_W'(cfg.half);
        rows_ok    = (row_reg >= half12) || (row_reg == cfg.h_m1);
        cols_ok    = (col_reg >= half12) || (col_reg == cfg.w_m1);
        rlo        = (row_reg >= half12) ? row_reg - half12 : '0;
        clo        = (col_reg >= half12) ? col_reg - half12 : '0;
        q_job.rlo   = rlo;
        q_job.rhi   = (row_reg == cfg.h_m1) ? row_reg : rlo;
        q_job.clo   = clo;
        q_job.chi   = (col_reg == cfg.w_m1) ? col_reg : clo;
        q_job.row   = row_reg;
        q_job.islot = 4'(islot_reg);
        q_job.pslot = 3'(pslot_reg);
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        int_we     = 1'b0;
        pix_we     = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            atint_pkg::F_IDLE: begin
                s_tready = q_empty;
                if (accept) begin
                    state_next = atint_pkg::F_CALC;
                end
            end
            atint_pkg::F_CALC: begin
                int_we     = 1'b1;
                pix_we     = 1'b1;
                q_push     = rows_ok && cols_ok;
                state_next = atint_pkg::F_IDLE;
            end
            default: state_next = atint_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atint_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_reg   <= '0;
            col_reg   <= '0;
            islot_reg <= '0;
            pslot_reg <= '0;
        end else if (accept) begin
            row_reg   <= row_e;
            col_reg   <= col_e;
            islot_reg <= islot_e;
            pslot_reg <= pslot_e;
        end else if (state_reg == atint_pkg::F_CALC) begin
            // Advance to the next raster position.
            if (col_reg == cfg.w_m1) begin
                col_reg <= '0;
                if (row_reg == cfg.h_m1) begin
                    row_reg   <= '0;
                    islot_reg <= '0;
                    pslot_reg <= '0;
                end else begin
                    row_reg   <= row_reg + 1'b1;
                    islot_reg <= (islot_reg == ISW'(INT_ROWS - 1)) ? '0 : islot_reg + 1'b1;
                    pslot_reg <= (pslot_reg == PSW'(PIX_ROWS - 1)) ? '0 : pslot_reg + 1'b1;
                end
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_tdata;
        end
        if (state_reg == atint_pkg::F_CALC) begin
            rowsum_reg <= rowsum_new;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/atint_queue.sv =====
// Short job queue between the front end and the window evaluator.
`default_nettype none
module atint_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire atint_pkg::job_t push_job,
    input  wire logic            pop,
    output atint_pkg::job_t      head,
    output logic                 empty,
    output logic                 full
);
    localparam int D  = atint_pkg::JOBQ_DEPTH;
    localparam int PW = $clog2(D);

    atint_pkg::job_t mem [D];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PW+1)'(D));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/atint_back.sv =====
// Back end: walks the released pixels of a job, sums each window and decides it.
`default_nettype none
module atint_back #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire atint_pkg::cfg_t cfg,
    input  wire atint_pkg::job_t job,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic [$clog2((MAX_WINDOW+1)*(2**$clog2(MAX_WIDTH)))-1:0] int_raddr,
    input  wire logic [$clog2(longint'(MAX_WIDTH)*MAX_HEIGHT*255+1)-1:0] int_rdata,
    output logic [$clog2((MAX_WINDOW/2+1)*(2**$clog2(MAX_WIDTH)))-1:0] pix_raddr,
    input  wire logic [7:0]      pix_rdata,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [atint_pkg::TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int INT_ROWS = MAX_WINDOW + 1;
    localparam int PIX_ROWS = MAX_WINDOW / 2 + 1;
    localparam int ISW      = $clog2(INT_ROWS);
    localparam int PSW      = (PIX_ROWS > 1) ? $clog2(PIX_ROWS) : 1;
    localparam int IW       = $clog2(longint'(MAX_WIDTH) * MAX_HEIGHT * 255 + 1);
    localparam int IAW      = $clog2(INT_ROWS * (2**CW));
    localparam int PAW      = $clog2(PIX_ROWS * (2**CW));
    localparam int PW       = atint_pkg::POS_W;

    // Step back d rows from slot s in a ring of n rows.
    function automatic logic [4:0] ring_back(input logic [4:0] s, input logic [4:0] d,
                                             input logic [4:0] n);
        logic [5:0] t;
        t = (s >= d) ? {1'b0, s} - {1'b0, d} : {1'b0, s} + {1'b0, n} - {1'b0, d};
        return t[4:0];
    endfunction

    atint_pkg::back_state_t state_reg, state_next;

    logic [PW-1:0]  r_reg, c_reg, r1_reg, c1_reg, r2_reg, c2_reg, c1m1_reg;
    logic [ISW-1:0] slot_r2_reg, slot_t_reg;
    logic [PSW-1:0] slot_p_reg;
    logic           has_top_reg, has_left_reg;
    logic [1:0]     idx_reg;
    logic [IW-1:0]  acc_reg;
    logic [7:0]     pix_reg;
    logic [7:0]     cnt_reg;
    logic [15:0]    prod_l_reg;
    logic [32:0]    prod_r_reg;
    logic           m_tvalid_reg, out_last_reg, out_fg_reg;
    logic [atint_pkg::OUT_POS_W-1:0] out_row_reg, out_col_reg;

    logic [PW-1:0]  half12, r1, c1, r2, c2;
    logic [PW:0]    r_sum, c_sum;
    logic [4:0]     d2, dt, dp;
    logic [1:0]     term;
    logic [IW-1:0]  acc_next;
    logic           out_free, is_last;
    logic [3:0]     rows_n, cols_n;

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (r_reg == job.rhi) && (c_reg == job.chi);

    // Window corners of the current pixel, clipped at the frame edges.
    always_comb begin
        half12 = PW'(cfg.half);
        r1     = (r_reg >= half12) ? r_reg - half12 : '0;
        c1     = (c_reg >= half12) ? c_reg - half12 : '0;
        r_sum  = {1'b0, r_reg} + (PW+1)'(cfg.half);
        c_sum  = {1'b0, c_reg} + (PW+1)'(cfg.half);
        r2     = (r_sum > {1'b0, cfg.h_m1}) ? cfg.h_m1 : r_sum[PW-1:0];
        c2     = (c_sum > {1'b0, cfg.w_m1}) ? cfg.w_m1 : c_sum[PW-1:0];
        d2     = 5'(job.row - r2);
        dt     = 5'(job.row - r1 + 1'b1);
        dp     = 5'(job.row - r_reg);
        rows_n = 4'(r2_reg - r1_reg + 1'b1);
        cols_n = 4'(c2_reg - c1_reg + 1'b1);
    end

    // Corner reads in order: bottom right, top right, bottom left, top left.
    always_comb begin
        case (idx_reg)
            2'd0:    int_raddr = IAW'({slot_r2_reg, c2_reg[CW-1:0]});
            2'd1:    int_raddr = IAW'({slot_t_reg, c2_reg[CW-1:0]});
            2'd2:    int_raddr = IAW'({slot_r2_reg, c1m1_reg[CW-1:0]});
            default: int_raddr = IAW'({slot_t_reg, c1m1_reg[CW-1:0]});
        endcase
        pix_raddr = PAW'({slot_p_reg, c_reg[CW-1:0]});
        term      = (state_reg == atint_pkg::B_DRAIN) ? 2'd3 : idx_reg - 2'd1;
        case (term)
            2'd0:    acc_next = acc_reg + int_rdata;
            2'd1:    acc_next = has_top_reg ? acc_reg - int_rdata : acc_reg;
            2'd2:    acc_next = has_left_reg ? acc_reg - int_rdata : acc_reg;
            default: acc_next = (has_top_reg && has_left_reg) ? acc_reg + int_rdata : acc_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            atint_pkg::B_IDLE: begin
                if (!q_empty) begin
                    state_next = atint_pkg::B_SETUP;
                end
            end
            atint_pkg::B_SETUP: state_next = atint_pkg::B_READ;
            atint_pkg::B_READ: begin
                if (idx_reg == 2'd3) begin
                    state_next = atint_pkg::B_DRAIN;
                end
            end
            atint_pkg::B_DRAIN: state_next = atint_pkg::B_MUL;
            atint_pkg::B_MUL:   state_next = atint_pkg::B_OUT;
            atint_pkg::B_OUT: begin
                if (out_free) begin
                    q_pop      = is_last;
                    state_next = is_last ? atint_pkg::B_IDLE : atint_pkg::B_SETUP;
                end
            end
            default: state_next = atint_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= atint_pkg::B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == atint_pkg::B_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            atint_pkg::B_IDLE: begin
                r_reg <= job.rlo;
                c_reg <= job.clo;
            end
            atint_pkg::B_SETUP: begin
                r1_reg       <= r1;
                c1_reg       <= c1;
                r2_reg       <= r2;
                c2_reg       <= c2;
                c1m1_reg     <= c1 - 1'b1;
                has_top_reg  <= (r1 != '0);
                has_left_reg <= (c1 != '0);
                slot_r2_reg  <= ISW'(ring_back(5'(job.islot), d2, 5'(INT_ROWS)));
                slot_t_reg   <= ISW'(ring_back(5'(job.islot), dt, 5'(INT_ROWS)));
                slot_p_reg   <= PSW'(ring_back(5'(job.pslot), dp, 5'(PIX_ROWS)));
                idx_reg      <= 2'd0;
                acc_reg      <= '0;
            end
            atint_pkg::B_READ: begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd0) begin
                    cnt_reg <= rows_n * cols_n;
                end else begin
                    acc_reg <= acc_next;
                end
                if (idx_reg == 2'd1) begin
                    pix_reg <= pix_rdata;
                end
            end
            atint_pkg::B_DRAIN: acc_reg <= acc_next;
            atint_pkg::B_MUL: begin
                prod_l_reg <= pix_reg * cnt_reg;
                prod_r_reg <= acc_reg[15:0] * (17'h10000 - {1'b0, cfg.thr});
            end
            atint_pkg::B_OUT: begin
                if (out_free) begin
                    out_row_reg  <= atint_pkg::OUT_POS_W'(r_reg);
                    out_col_reg  <= atint_pkg::OUT_POS_W'(c_reg);
                    out_fg_reg   <= {1'b0, prod_l_reg, 16'h0000} > prod_r_reg;
                    out_last_reg <= is_last;
                    if (c_reg == job.chi) begin
                        c_reg <= job.clo;
                        r_reg <= r_reg + 1'b1;
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_fg_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/adaptive_threshold_integral.sv =====
// Top level of the streaming adaptive threshold block over an integral image.
//
// Usage:
//   s_ channel: one 8-bit grey pixel per item, raster order, frame of
//   frame_width x frame_height set through the cfg_ write port.
//   m_ channel: one decision per item: row, column and foreground flag;
//   tlast marks the final decision released by one input pixel.
//   In the front end each pixel takes an integral read, then a write.
//   A pixel that releases decisions holds off the next pixel until the
//   evaluator is done: for each decision it reads four window corners
//   one at a time from the single read port of the integral store, then
//   multiplies and compares. A pixel releases up to 64 decisions, the
//   most at the frame's last pixel with a window of 15.
//   Reset restores the register defaults and the frame position (0,0); the
//   row stores need no clearing pass. Writing width, height or window size
//   restarts the frame. A stalled receiver holds the output item; the
//   evaluator then waits and the input stays blocked until it is taken.
`default_nettype none
module adaptive_threshold_integral #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [10:0] out_row, [21:11] out_col, [22] foreground
    output logic             m_tlast,   // last_of_run
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int INT_ROWS = MAX_WINDOW + 1;
    localparam int PIX_ROWS = MAX_WINDOW / 2 + 1;
    localparam int IW       = $clog2(longint'(MAX_WIDTH) * MAX_HEIGHT * 255 + 1);
    localparam int INT_D    = INT_ROWS * (2**CW);
    localparam int PIX_D    = PIX_ROWS * (2**CW);
    localparam int IAW      = $clog2(INT_D);
    localparam int PAW      = $clog2(PIX_D);

    logic [11:0] frame_width_reg, frame_height_reg;
    logic [3:0]  window_size_reg;
    logic [15:0] threshold_reg;

    atint_pkg::cfg_t cfg;
    atint_pkg::job_t push_job, head_job;
    logic            restart, q_push, q_pop, q_empty, q_full;
    logic [12:0]     w_eff, h_eff;
    logic [3:0]      ws_eff;

    logic            int_we, pix_we;
    logic [IAW-1:0]  int_waddr, f_raddr, b_raddr, int_raddr;
    logic [IW-1:0]   int_wdata, int_rdata;
    logic [PAW-1:0]  pix_waddr, pix_raddr;
    logic [7:0]      pix_wdata, pix_rdata;

    // Configuration registers; geometry writes restart the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 12'd512;
            frame_height_reg <= 12'd512;
            window_size_reg  <= 4'd15;
            threshold_reg    <= 16'd9830;
        end else if (cfg_we) begin
            case (cfg_index)
                atint_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[11:0];
                atint_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[11:0];
                atint_pkg::REG_WINDOW_SIZE:  window_size_reg  <= cfg_wdata[3:0];
                atint_pkg::REG_THRESHOLD:    threshold_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index != atint_pkg::REG_THRESHOLD);

    // Clamp the geometry: zero counts as one, large values saturate.
    always_comb begin
        w_eff = (frame_width_reg == '0) ? 13'd1 :
                ({1'b0, frame_width_reg} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) :
                {1'b0, frame_width_reg};
        h_eff = (frame_height_reg == '0) ? 13'd1 :
                ({1'b0, frame_height_reg} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) :
                {1'b0, frame_height_reg};
        ws_eff   = (window_size_reg > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : window_size_reg;
        cfg.w_m1 = 12'(w_eff - 13'd1);
        cfg.h_m1 = 12'(h_eff - 13'd1);
        cfg.half = ws_eff[3:1];
        cfg.thr  = threshold_reg;
    end

    // The front end owns the read port only while no job is outstanding.
    assign int_raddr = q_empty ? f_raddr : b_raddr;

    atint_ram #(.WIDTH(IW), .DEPTH(INT_D)) u_int_ram (
        .aclk  (aclk),
        .we    (int_we),
        .waddr (int_waddr),
        .wdata (int_wdata),
        .raddr (int_raddr),
        .rdata (int_rdata)
    );

    atint_ram #(.WIDTH(8), .DEPTH(PIX_D)) u_pix_ram (
        .aclk  (aclk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    atint_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .restart   (restart),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .int_we    (int_we),
        .int_waddr (int_waddr),
        .int_wdata (int_wdata),
        .int_raddr (f_raddr),
        .int_rdata (int_rdata),
        .pix_we    (pix_we),
        .pix_waddr (pix_waddr),
        .pix_wdata (pix_wdata),
        .q_empty   (q_empty),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    atint_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    atint_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job       (head_job),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .int_raddr (b_raddr),
        .int_rdata (int_rdata),
        .pix_raddr (pix_raddr),
        .pix_rdata (pix_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/atint_checker.sv =====
// Port-level checker for the adaptive threshold block, bound to the top level.
`default_nettype none
`include "adaptive_threshold_integral_macros.svh"
module atint_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);
    `ATI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output item dropped while stalled")
    `ATI_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled output item changed")
    `ATI_ASSERT_NEXT(a_in_pause, s_tvalid && s_tready, !s_tready, "input taken on consecutive cycles")
    `ATI_ASSERT_ALWAYS(a_reset_quiet, !aresetn, !m_tvalid, "output valid right after reset")
endmodule

bind adaptive_threshold_integral atint_checker u_atint_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== bench/tb_adaptive_threshold_integral.sv =====
// Self-checking testbench for the adaptive threshold block over an integral image.
`default_nettype none
module tb_adaptive_threshold_integral;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 2048;
    localparam int MAXH = 2048;
    localparam int INT_ROWS = 16;
    localparam int PIX_ROWS = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 600;

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] col;
        logic        fg;
        logic        last;
    } decision_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire         m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    adaptive_threshold_integral uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the block: registers, position and row stores
    logic [11:0] shd_width, shd_height;
    logic [3:0]  shd_window;
    logic [15:0] shd_thr;
    int unsigned shd_row, shd_col;
    longint unsigned integ[INT_ROWS][MAXW];
    logic [7:0]  pix[PIX_ROWS][MAXW];

    decision_t pending_decisions[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  no_stall = 1'b0;
    bit  no_gap = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic int unsigned eff_w();
        if (shd_width == 0) return 1;
        return (shd_width > MAXW) ? MAXW : shd_width;
    endfunction

    function automatic int unsigned eff_h();
        if (shd_height == 0) return 1;
        return (shd_height > MAXH) ? MAXH : shd_height;
    endfunction

    function automatic longint unsigned isum(input int unsigned r, input int unsigned c);
        return integ[r % INT_ROWS][c];
    endfunction

    // Advance the shadow by one pixel and queue the decisions it releases
    task automatic predict_pixel(input logic [7:0] p);
        int unsigned w, h, hf, rr, cc, rlo, rhi, clo, chi, r1, c1, r2, c2, n;
        longint unsigned ab, lf, dg, cnt, s, lhs, rhs;
        decision_t d;
        w = eff_w();
        h = eff_h();
        hf = shd_window / 2;
        n = 0;
        if (shd_row >= h || shd_col >= w) begin
            shd_row = 0;
            shd_col = 0;
        end
        pix[shd_row % PIX_ROWS][shd_col] = p;
        ab = (shd_row > 0) ? isum(shd_row - 1, shd_col) : 0;
        lf = (shd_col > 0) ? isum(shd_row, shd_col - 1) : 0;
        dg = (shd_row > 0 && shd_col > 0) ? isum(shd_row - 1, shd_col - 1) : 0;
        integ[shd_row % INT_ROWS][shd_col] = p + ab + lf - dg;
        if ((shd_row >= hf || shd_row == h - 1) && (shd_col >= hf || shd_col == w - 1)) begin
            rlo = (shd_row >= hf) ? shd_row - hf : 0;
            rhi = (shd_row == h - 1) ? shd_row : rlo;
            clo = (shd_col >= hf) ? shd_col - hf : 0;
            chi = (shd_col == w - 1) ? shd_col : clo;
            for (rr = rlo; rr <= rhi; rr++) begin
                for (cc = clo; cc <= chi; cc++) begin
                    r1 = (rr >= hf) ? rr - hf : 0;
                    c1 = (cc >= hf) ? cc - hf : 0;
                    r2 = (rr + hf < h) ? rr + hf : h - 1;
                    c2 = (cc + hf < w) ? cc + hf : w - 1;
                    cnt = longint'(r2 - r1 + 1) * longint'(c2 - c1 + 1);
                    s = isum(r2, c2);
                    if (r1 > 0) s -= isum(r1 - 1, c2);
                    if (c1 > 0) s -= isum(r2, c1 - 1);
                    if (r1 > 0 && c1 > 0) s += isum(r1 - 1, c1 - 1);
                    lhs = longint'(pix[rr % PIX_ROWS][cc]) * cnt * 65536;
                    rhs = s * (65536 - longint'(shd_thr));
                    d.row = rr[10:0];
                    d.col = cc[10:0];
                    d.fg = (lhs > rhs);
                    d.last = 1'b0;
                    pending_decisions.insert(pending_decisions.size(), d);
                    n++;
                end
            end
            if (n > 0) pending_decisions[$].last = 1'b1;
        end
        shd_col++;
        if (shd_col >= w) begin
            shd_col = 0;
            shd_row++;
            if (shd_row >= h) shd_row = 0;
        end
    endtask

    // Send one pixel; the shadow advances when the item is taken
    task automatic send_pixel(input logic [7:0] p);
        if (!no_gap && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(p);
    endtask

    // Wait until every decision has arrived, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        case (idx)
            atint_pkg::REG_FRAME_WIDTH: begin
                shd_width = v[11:0]; shd_row = 0; shd_col = 0;
            end
            atint_pkg::REG_FRAME_HEIGHT: begin
                shd_height = v[11:0]; shd_row = 0; shd_col = 0;
            end
            atint_pkg::REG_WINDOW_SIZE: begin
                shd_window = v[3:0]; shd_row = 0; shd_col = 0;
            end
            atint_pkg::REG_THRESHOLD: shd_thr = v;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int win, input int thr);
        drain();
        write_reg(atint_pkg::REG_FRAME_WIDTH, w[15:0]);
        write_reg(atint_pkg::REG_FRAME_HEIGHT, h[15:0]);
        write_reg(atint_pkg::REG_WINDOW_SIZE, win[15:0]);
        write_reg(atint_pkg::REG_THRESHOLD, thr[15:0]);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input int mode);
        int n;
        n = eff_w() * eff_h();
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: send_pixel(8'($urandom_range(0, 255)));
                1: send_pixel((i % 2) ? 8'hFF : 8'h00);
                default: send_pixel(($urandom_range(0, 3) == 0) ? 8'hFF : 8'h10);
            endcase
        end
    endtask

    // Extremes of pixel and threshold on a tiny frame, single pixel frame
    task automatic test_directed();
        set_geometry(4, 3, 3, 0);
        send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h80); send_pixel(8'h7F);
        send_pixel(8'hFF); send_pixel(8'h01); send_pixel(8'hFE); send_pixel(8'h00);
        send_pixel(8'h55); send_pixel(8'hAA); send_pixel(8'hFF); send_pixel(8'h00);
        set_geometry(1, 1, 1, 65535);
        send_pixel(8'hFF); send_pixel(8'h00);
        set_geometry(0, 0, 0, 32768);
        send_pixel(8'h42);
        // window far larger than the frame, clipping everywhere
        set_geometry(2, 3, 15, 9830);
        send_frame(1);
    endtask

    // Geometry change in mid-frame restarts at the origin
    task automatic test_restart();
        set_geometry(5, 4, 5, 9830);
        repeat (7) send_pixel(8'($urandom_range(0, 255)));
        set_geometry(5, 4, 4, 1000);
        send_frame(0);
    endtask

    // Long receiver hold-off while pixels keep coming
    task automatic test_backpressure();
        set_geometry(6, 6, 7, 9830);
        no_gap = 1'b1;
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_frame(0);
        join
        no_gap = 1'b0;
        drain();
    endtask

    // Random frames of mostly small size, a few wide/tall ones at the extremes
    task automatic test_random();
        int w, h;
        for (int f = 0; f < 8; f++) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            no_stall = (f == 3);
            set_geometry(w, h, $urandom_range(0, 15), $urandom_range(0, 65535));
            send_frame($urandom_range(0, 2));
        end
        no_stall = 1'b0;
        set_geometry(2048, 1, 15, 9830);
        repeat (20) send_pixel(8'($urandom_range(0, 255)));
        set_geometry(1, 2048, 3, 65535);
        repeat (15) send_pixel(8'($urandom_range(0, 255)));
        set_geometry(4095, 4095, 15, 0);
        repeat (10) send_pixel(8'($urandom_range(0, 255)));
    endtask

    // Receiver: hold-off window, its own stall pattern, and the checker
    always @(posedge aclk) begin
        decision_t exp_d;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_decisions.size() == 0) begin
                    report_mismatch($sformatf("unexpected decision %h", m_tdata));
                end else begin
                    exp_d = pending_decisions.pop_front();
                    if (m_tdata[10:0] !== exp_d.row)
                        report_mismatch($sformatf("row %0d, want %0d", m_tdata[10:0], exp_d.row));
                    if (m_tdata[21:11] !== exp_d.col)
                        report_mismatch($sformatf("col %0d, want %0d", m_tdata[21:11], exp_d.col));
                    if (m_tdata[22] !== exp_d.fg)
                        report_mismatch($sformatf("fg at (%0d,%0d) %b, want %b",
                            exp_d.row, exp_d.col, m_tdata[22], exp_d.fg));
                    if (m_tlast !== exp_d.last)
                        report_mismatch($sformatf("tlast at (%0d,%0d) %b, want %b",
                            exp_d.row, exp_d.col, m_tlast, exp_d.last));
                end
            end
            if (hold_off) m_tready <= 1'b0;
            else if (no_stall) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 9) > 2);
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        shd_width = 512; shd_height = 512; shd_window = 15; shd_thr = 9830;
        shd_row = 0; shd_col = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_restart();
        test_backpressure();
        test_random();
        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && pending_decisions.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
